// ===== hdl/bmpu_pkg.sv =====
// Package for the bitmap pixel stream unpacker.
// Holds shared widths, register indexes, byte-count codes and the pixel struct.
// No dependencies.
package bmpu_pkg;

  localparam int DefMaxDimension = 4096;

  localparam int DIM_CFG_W  = 13;
  localparam int BPP_CFG_W  = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int INDEX_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_UP       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 8'd3;

  localparam logic [BPP_CFG_W-1:0] BPP_ONE  = 3'd1;
  localparam logic [BPP_CFG_W-1:0] BPP_BGR  = 3'd3;
  localparam logic [BPP_CFG_W-1:0] BPP_BGRA = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [INDEX_W-1:0] pixel_index;
    logic               frame_done;
  } pix_t;

endpackage

// ===== hdl/bmpu_ifs.sv =====
// Channel interfaces of the bitmap pixel stream unpacker: byte input,
// pixel output and configuration write. Depends on bmpu_pkg.
interface bmpu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface bmpu_out_if import bmpu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic [INDEX_W-1:0] pixel_index;
  logic               frame_done;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output pixel_index, output frame_done, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input pixel_index, input frame_done, output ready);
endinterface

interface bmpu_cfg_if import bmpu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bmp_pixel_stream_unpacker.sv =====
// Top level of the bitmap pixel stream unpacker: byte-to-RGBA conversion,
// row padding skip, destination indexing and a two-entry output buffer.
// Depends on bmpu_pkg and the interfaces in bmpu_ifs.sv.
//
// Usage:
//   in_chan  : one byte of the bitmap pixel array per transfer, row padding
//              included. A byte is taken every cycle while in_chan.ready is high.
//   out_chan : one RGBA pixel per transfer with its destination index
//              (row * width + column) and frame_done on the last image pixel.
//   cfg_chan : register writes (0 width, 1 height, 2 bottom_up,
//              3 bytes_per_pixel); always ready, write only while idle.
//   Output: a pixel is registered into the output register, or into the skid entry
//   while the output register holds a waiting pixel. Throughput: one byte per cycle
//   while in_chan.ready is high, set by the byte/column/row counters and multiplier.
//   Stall: the output register plus one skid entry keep in_chan ready while
//   one pixel waits; in_chan.ready drops only when both entries are full.
//   Reset (rst_n low, synchronous): counters and buffer cleared, registers
//   return to width 1, height 1, bottom_up 1, three bytes per pixel.
module bmp_pixel_stream_unpacker import bmpu_pkg::*; #(
  parameter int MAX_DIMENSION = DefMaxDimension
) (
  input  logic              clk,
  input  logic              rst_n,
  bmpu_in_if.sink           in_chan,
  bmpu_out_if.source        out_chan,
  bmpu_cfg_if.sink          cfg_chan
);

  localparam int CW = $clog2(MAX_DIMENSION);
  localparam int WW = (CW + 1 > DIM_CFG_W) ? CW + 1 : DIM_CFG_W;
  localparam logic [WW-1:0] MaxDim = WW'(MAX_DIMENSION);

  // configuration registers
  logic [DIM_CFG_W-1:0] width_r, height_r;
  logic                 bottom_up_r;
  logic [BPP_CFG_W-1:0] bpp_r;

  // unpack state
  logic [1:0]    byte_pos_r, byte_pos_nxt;
  logic [23:0]   held_r, held_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [CW-1:0] row_cnt_r, row_cnt_nxt;
  logic [1:0]    pad_left_r, pad_left_nxt;

  // output buffer
  pix_t main_r, skid_r;
  logic main_v_r, skid_v_r;

  logic in_fire, out_fire, cfg_fire;
  logic res_v;
  pix_t res;

  logic [WW-1:0]        w_eff, h_eff, col, row, dest_row;
  logic [BPP_CFG_W-1:0] bpp;
  logic [2*WW-1:0]      row_prod;
  logic                 complete, col_last, row_last;
  logic [1:0]           pad;

  assign in_chan.ready  = !skid_v_r;
  assign cfg_chan.ready = 1'b1;
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = main_v_r && out_chan.ready;
  assign cfg_fire = cfg_chan.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_CFG_W'(1);
      height_r    <= DIM_CFG_W'(1);
      bottom_up_r <= 1'b1;
      bpp_r       <= BPP_BGR;
    end else if (cfg_fire) begin
      case (cfg_chan.index)
        REG_IMAGE_WIDTH:     width_r     <= cfg_chan.data[DIM_CFG_W-1:0];
        REG_IMAGE_HEIGHT:    height_r    <= cfg_chan.data[DIM_CFG_W-1:0];
        REG_BOTTOM_UP:       bottom_up_r <= cfg_chan.data[0];
        REG_BYTES_PER_PIXEL: bpp_r       <= cfg_chan.data[BPP_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [WW-1:0] wx, hx;
    wx = WW'(width_r);
    hx = WW'(height_r);
    w_eff = (wx == '0) ? WW'(1) : ((wx > MaxDim) ? MaxDim : wx);
    h_eff = (hx == '0) ? WW'(1) : ((hx > MaxDim) ? MaxDim : hx);
    bpp   = (bpp_r >= BPP_ONE && bpp_r <= BPP_BGRA) ? bpp_r : BPP_ONE;
  end

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    held_nxt     = held_r;
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    pad_left_nxt = pad_left_r;
    res_v        = 1'b0;

    complete = ({1'b0, byte_pos_r} + 3'd1) >= bpp;
    col      = (WW'(col_cnt_r) < w_eff) ? WW'(col_cnt_r) : w_eff - WW'(1);
    row      = (WW'(row_cnt_r) < h_eff) ? WW'(row_cnt_r) : h_eff - WW'(1);
    dest_row = bottom_up_r ? (h_eff - WW'(1) - row) : row;
    row_prod = (2*WW)'(dest_row) * (2*WW)'(w_eff);
    col_last = (WW'(col_cnt_r) + WW'(1)) >= w_eff;
    row_last = (WW'(row_cnt_r) + WW'(1)) >= h_eff;
    // padding to the next 4-byte boundary only depends on the low bits
    pad      = 2'(2'd0 - 2'(w_eff[1:0] * bpp[1:0]));

    res.red         = 8'd0;
    res.green       = 8'd0;
    res.blue        = 8'd0;
    res.alpha       = ALPHA_OPAQUE;
    res.pixel_index = row_prod[INDEX_W-1:0] + INDEX_W'(col);
    res.frame_done  = 1'b0;
    case (bpp)
      BPP_BGR: begin
        res.blue  = held_r[7:0];
        res.green = held_r[15:8];
        res.red   = in_chan.data_byte;
      end
      BPP_BGRA: begin
        res.blue  = held_r[7:0];
        res.green = held_r[15:8];
        res.red   = held_r[23:16];
        res.alpha = in_chan.data_byte;
      end
      default: ;
    endcase

    if (in_fire) begin
      if (pad_left_r != 2'd0) begin
        pad_left_nxt = pad_left_r - 2'd1;
      end else if (!complete) begin
        held_nxt     = held_r | (24'(in_chan.data_byte) << {byte_pos_r, 3'b000});
        byte_pos_nxt = byte_pos_r + 2'd1;
      end else begin
        res_v        = 1'b1;
        held_nxt     = '0;
        byte_pos_nxt = 2'd0;
        if (col_last) begin
          pad_left_nxt = pad;
          col_cnt_nxt  = '0;
          if (row_last) begin
            row_cnt_nxt    = '0;
            res.frame_done = 1'b1;
          end else begin
            row_cnt_nxt = row_cnt_r + CW'(1);
          end
        end else begin
          col_cnt_nxt = col_cnt_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= 2'd0;
      held_r     <= '0;
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      pad_left_r <= 2'd0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      held_r     <= held_nxt;
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      pad_left_r <= pad_left_nxt;
    end
  end

  // output register with one skid entry; a new pixel never arrives while skid is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_fire) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= res_v;
      end
    end else if (res_v) begin
      if (main_v_r) begin
        skid_v_r <= 1'b1;
      end else begin
        main_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      if (skid_v_r) begin
        main_r <= skid_r;
      end else begin
        main_r <= res;
      end
    end else if (res_v) begin
      if (main_v_r) begin
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end
  end

  assign out_chan.valid       = main_v_r;
  assign out_chan.red         = main_r.red;
  assign out_chan.green       = main_r.green;
  assign out_chan.blue        = main_r.blue;
  assign out_chan.alpha       = main_r.alpha;
  assign out_chan.pixel_index = main_r.pixel_index;
  assign out_chan.frame_done  = main_r.frame_done;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry valid while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && skid_v_r) |=> (!skid_v_r && main_v_r))
    else $error("skid entry not moved to output register");

  a_pad_between_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (pad_left_r != 2'd0) |-> (byte_pos_r == 2'd0))
    else $error("padding pending inside a pixel");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v && res.frame_done) |=> (row_cnt_r == '0 && col_cnt_r == '0))
    else $error("counters not restarted after last pixel");

endmodule
